// ===== hw/rtl/uwb_frame_trilateration_core_assert.svh =====
// Assertion macros shared by the checker of the trilateration core.
// Plain text macros only; no other dependencies.
`ifndef UWB_FRAME_TRILATERATION_CORE_ASSERT_SVH
`define UWB_FRAME_TRILATERATION_CORE_ASSERT_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is low.
`define UFTRI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("uftri: assertion failed");

// Same, with a caller supplied message.
`define UFTRI_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/uftri_pkg.sv =====
// Shared constants and types of the two-anchor trilateration core.
// No dependencies.
`default_nettype none

package uftri_pkg;

  localparam int unsigned WinDepth  = 9;
  localparam int unsigned DivSteps  = 33;
  localparam int unsigned RootSteps = 16;
  localparam int unsigned CntW      = $clog2(DivSteps);

  localparam logic [7:0] Hdr0 = 8'hAC;
  localparam logic [7:0] Hdr1 = 8'hDA;
  localparam logic [7:0] Hdr2 = 8'h00;
  localparam logic [7:0] Hdr5 = 8'h03;

  localparam logic [15:0] BaselineReset = 16'd1000;

  // Header match and the two ranges seen in the current window.
  typedef struct packed {
    logic        match;
    logic [15:0] range_a;
    logic [15:0] range_b;
  } uftri_win_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uftri_window.sv =====
// Sliding byte window with frame header detection.
// Depends on uftri_pkg.
`default_nettype none

module uftri_window import uftri_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  output uftri_win_t      win_o
);

  logic [7:0] byte_q [WinDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinDepth; i++) byte_q[i] <= 8'h00;
    end else if (shift_i) begin
      for (int i = 0; i < WinDepth - 1; i++) byte_q[i] <= byte_q[i+1];
      byte_q[WinDepth-1] <= byte_i;
    end
  end

  // Held bytes 0..8 plus the incoming byte form the ten-byte window.
  always_comb begin
    win_o.match   = (byte_q[0] == Hdr0) && (byte_q[1] == Hdr1) &&
                    (byte_q[2] == Hdr2) && (byte_q[5] == Hdr5);
    win_o.range_a = {byte_q[6], byte_q[7]};
    win_o.range_b = {byte_q[8], byte_i};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uftri_solver.sv =====
// Sequenced solver: one 16x16 squarer, a bit-serial divider and a
// digit-serial square root share a small state machine; holds the output register.
// Depends on uftri_pkg.
`default_nettype none

module uftri_solver import uftri_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire uftri_win_t  win_i,
  input  wire logic [15:0] baseline_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [16:0]      pos_x_o,
  output logic [15:0]      pos_y_o
);

  typedef enum logic [3:0] {
    StIdle, StSqA, StSqB, StSqL, StNum, StDiv, StChk, StSqQ, StRInit, StRoot, StDone
  } state_e;

  state_e      state_q;
  logic [CntW-1:0] cnt_q;
  logic [15:0] a_q, b_q, l_q;
  logic [31:0] mul_q, asq_q, bsq_q;
  logic        neg_q;
  logic [32:0] dvd_q;
  logic [16:0] drem_q;
  logic [31:0] v_q;
  logic [17:0] srem_q;
  logic [15:0] root_q;
  logic        ovalid_q;
  logic [16:0] pos_x_q;
  logic [15:0] pos_y_q;

  logic [15:0] mul_op;
  logic [31:0] mul_d;
  logic [33:0] num;
  logic [33:0] num_mag;
  logic [16:0] den;
  logic [17:0] div_rs;
  logic        div_ge;
  logic [17:0] div_diff;
  logic [19:0] rt_rs, rt_trial, rt_diff;
  logic        rt_ge;
  logic [16:0] q17;

  always_comb begin
    case (state_q)
      StSqA:   mul_op = a_q;
      StSqB:   mul_op = b_q;
      StSqL:   mul_op = l_q;
      StSqQ:   mul_op = dvd_q[15:0];
      default: mul_op = a_q;
    endcase
    mul_d = mul_op * mul_op;

    // A^2 - B^2 + L^2, signed 34 bits
    num     = {2'b00, asq_q} - {2'b00, bsq_q} + {2'b00, mul_q};
    num_mag = num[33] ? (34'd0 - num) : num;

    den      = {l_q, 1'b0};
    div_rs   = {drem_q, dvd_q[32]};
    div_ge   = div_rs >= {1'b0, den};
    div_diff = div_rs - {1'b0, den};

    rt_rs    = {srem_q, v_q[31:30]};
    rt_trial = {2'b00, root_q, 2'b01};
    rt_ge    = rt_rs >= rt_trial;
    rt_diff  = rt_rs - rt_trial;

    q17 = {1'b0, dvd_q[15:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      // in the final state the result register is reloaded below
      if (ovalid_q && out_ready_i && (state_q != StDone)) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            a_q     <= win_i.range_a;
            b_q     <= win_i.range_b;
            l_q     <= baseline_i;
            state_q <= StSqA;
          end
        end
        StSqA: begin
          mul_q   <= mul_d;
          state_q <= StSqB;
        end
        StSqB: begin
          asq_q   <= mul_q;
          mul_q   <= mul_d;
          state_q <= StSqL;
        end
        StSqL: begin
          bsq_q   <= mul_q;
          mul_q   <= mul_d;
          state_q <= StNum;
        end
        StNum: begin
          neg_q   <= num[33];
          dvd_q   <= num_mag[32:0];
          drem_q  <= '0;
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          drem_q <= div_ge ? div_diff[16:0] : div_rs[16:0];
          dvd_q  <= {dvd_q[31:0], div_ge};
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_q <= StChk;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StChk: begin
          // |X| >= A leaves no positive discriminant
          if (dvd_q >= {17'd0, a_q}) state_q <= StIdle;
          else                       state_q <= StSqQ;
        end
        StSqQ: begin
          mul_q   <= mul_d;
          state_q <= StRInit;
        end
        StRInit: begin
          v_q     <= asq_q - mul_q;
          srem_q  <= '0;
          root_q  <= '0;
          cnt_q   <= '0;
          state_q <= StRoot;
        end
        StRoot: begin
          srem_q <= rt_ge ? rt_diff[17:0] : rt_rs[17:0];
          root_q <= {root_q[14:0], rt_ge};
          v_q    <= {v_q[29:0], 2'b00};
          if (cnt_q == CntW'(RootSteps - 1)) begin
            state_q <= StDone;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StDone: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b1;
            pos_x_q  <= neg_q ? (17'd0 - q17) : q17;
            pos_y_q  <= root_q;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = ovalid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;

endmodule

`default_nettype wire

// ===== hw/rtl/uwb_frame_trilateration_core.sv =====
// Channel   Dir  Transaction          Payload
// s_axis    in   one stream byte      tdata[7:0] = in_byte
// m_axis    out  one position result  tdata[16:0] = pos_x, [32:17] = pos_y, [39:33] zero
// cfg       in   baseline write       cfg_wdata_i[15:0] = anchor_baseline
//
// A byte that completes no frame header leaves the solver idle; s_axis_tready stays high.
// A byte that completes a frame starts the solver unless the baseline is zero: tready is
// low while it runs the 33-step restoring divider and the 16-step root on one shared
// datapath; the pass ends after the divider when |X| >= A and no result follows.
// The output register lets a result wait while new bytes are taken; a stalled
// result holds the solver in its final state until the register frees.
// Reset clears the window to zeros and loads a baseline of 1000.
`default_nettype none

module uwb_frame_trilateration_core import uftri_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [16:0] pos_x, [32:17] pos_y, [39:33] zero
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [15:0] baseline_q;
  logic        busy;
  logic        in_accept;
  logic        start;
  uftri_win_t  win;
  logic [16:0] pos_x;
  logic [15:0] pos_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= BaselineReset;
    end else if (cfg_we_i) begin
      baseline_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  // zero baseline yields no result
  assign start         = in_accept && win.match && (baseline_q != 16'd0);

  uftri_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (in_accept),
    .byte_i  (s_axis_tdata),
    .win_o   (win)
  );

  uftri_solver u_solver (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .win_i       (win),
    .baseline_i  (baseline_q),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y)
  );

  assign m_axis_tdata = {7'd0, pos_y, pos_x};

endmodule

`default_nettype wire

// ===== hw/rtl/uftri_checker.sv =====
// Port-level checker for the trilateration core, bound to the top level.
// Depends on uwb_frame_trilateration_core_assert.svh.
`default_nettype none

`include "uwb_frame_trilateration_core_assert.svh"

module uftri_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // stalled result holds
  `UFTRI_ASSERT_MSG(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "uftri: stalled result changed")

  // the core goes busy only right after taking a byte
  `UFTRI_ASSERT(a_busy_after_accept, clk_i, rst_ni, $fell(s_axis_tready) |-> $past(s_axis_tvalid))

  // a new result appears only while the solver runs
  `UFTRI_ASSERT(a_result_from_solver, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

  // |X| < 65536 and pad bits are zero
  `UFTRI_ASSERT_MSG(a_result_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[16:0] != 17'h10000) && (m_axis_tdata[39:33] == 7'd0), "uftri: result out of range")

endmodule

bind uwb_frame_trilateration_core uftri_checker u_uftri_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench of uwb_frame_trilateration_core: streams framed range bytes,
// predicts each position fix in a scoreboard class and checks every result transaction.
// Depends on uftri_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import uftri_pkg::*;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [15:0] pos_y;
  } position_t;

  // Tracks the byte window and baseline, and queues the fixes still due from the core.
  class trilat_scoreboard;
    bit [7:0]    held [WinDepth];
    bit [15:0]   baseline;
    position_t   fixes_due[$];
    int unsigned fails;

    function new();
      foreach (held[i]) held[i] = 8'h00;
      baseline = BaselineReset;
      fails = 0;
    endfunction

    function void take_byte(bit [7:0] din);
      bit [7:0]  w [WinDepth + 1];
      longint    ra, rb, l, num, q, rem, trial;
      bit [15:0] root;
      position_t fix;
      foreach (held[i]) w[i] = held[i];
      w[WinDepth] = din;
      l = baseline;
      if (w[0] == Hdr0 && w[1] == Hdr1 && w[2] == Hdr2 && w[5] == Hdr5 && l != 0) begin
        ra = {w[6], w[7]};
        rb = {w[8], w[9]};
        num = ra * ra - rb * rb + l * l;
        // quotient on the magnitude, so the signed result truncates toward zero
        q = (num < 0 ? -num : num) / (2 * l);
        if (q < ra) begin
          rem = ra * ra - q * q;
          root = '0;
          for (int k = 15; k >= 0; k--) begin
            trial = root | (1 << k);
            if (trial * trial <= rem) root = trial[15:0];
          end
          fix.pos_x = (num < 0) ? 17'(-q) : 17'(q);
          fix.pos_y = root;
          fixes_due.push_back(fix);
        end
      end
      for (int i = 0; i < WinDepth; i++) held[i] = w[i + 1];
    endfunction

    function void check_fix(logic [39:0] d);
      position_t want;
      if (fixes_due.size() == 0) begin
        fails++;
        $display("%0t tb: result with none due, expected nothing, got %h", $time, d);
        return;
      end
      want = fixes_due.pop_front();
      if (d[16:0] !== want.pos_x) begin
        fails++;
        $display("%0t tb: pos_x expected %0d got %0d", $time,
                 $signed(want.pos_x), $signed(d[16:0]));
      end
      if (d[32:17] !== want.pos_y) begin
        fails++;
        $display("%0t tb: pos_y expected %0d got %0d", $time, want.pos_y, d[32:17]);
      end
      if (d[39:33] !== 7'd0) begin
        fails++;
        $display("%0t tb: pad bits expected 0 got %h", $time, d[39:33]);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // [16:0] pos_x, [32:17] pos_y, [39:33] zero
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;

  trilat_scoreboard sb;
  bit          gaps_on = 1'b1;
  int unsigned bytes_sent = 0;

  uwb_frame_trilateration_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: random backpressure, checked on each accepted transaction.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !gaps_on || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_fix(m_axis_tdata);
  end

  // tvalid is only lowered while idling, so back-to-back bytes never toggle it in one step.
  task automatic send_byte(input bit [7:0] b);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  // bad_pos < 0 keeps the header intact; keep < 10 cuts the frame short.
  task automatic send_frame(input bit [15:0] ra, input bit [15:0] rb, input int bad_pos,
                            input int keep);
    bit [7:0] f [10];
    f = '{Hdr0, Hdr1, Hdr2, 8'($urandom_range(255)), 8'($urandom_range(255)), Hdr5,
          ra[15:8], ra[7:0], rb[15:8], rb[7:0]};
    if (bad_pos >= 0) f[bad_pos] ^= 8'($urandom_range(255, 1));
    for (int i = 0; i < keep; i++) send_byte(f[i]);
  endtask

  // Ranges that mostly satisfy the triangle inequality, so a fix usually comes out.
  function automatic void pick_ranges(input int l, output bit [15:0] ra, output bit [15:0] rb);
    int a, lo, hi;
    a  = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom_range(3000, 1);
    lo = (a > l ? a - l : l - a) + 1;
    hi = a + l - 1;
    if (hi > 65535) hi = 65535;
    ra = 16'(a);
    rb = (l == 0 || lo > hi) ? 16'($urandom_range(65535)) : 16'($urandom_range(hi, lo));
  endfunction

  // Drain: wait out every due fix plus a solver pass that may end without a result.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.fixes_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_baseline(input bit [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.baseline = v;
  endtask

  initial begin
    bit [7:0]    opening [29];
    int unsigned base [8];
    int unsigned goal;
    int          r, sel;
    bit [15:0]   ra, rb;

    sb = new();
    // early bytes, a negative-X fix, then overlapping frames ending on a zero discriminant
    opening = '{8'h00, 8'h03, 8'hFF,
      8'hAC, 8'hDA, 8'h00, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'hC8, 8'h04, 8'h4C,
      8'hAC, 8'hDA, 8'h00, 8'h00, 8'h00, 8'h03, 8'hAC, 8'hDA, 8'h00, 8'h00,
      8'h00, 8'h03, 8'h01, 8'hF4, 8'h01, 8'hF4};
    base = '{1000, 1, 65535, 0, $urandom_range(65535, 1), $urandom_range(40, 2),
             $urandom_range(5000, 500), 2};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    goal = 0;
    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        settle();
        write_baseline(16'(base[p]));
      end
      gaps_on = (p != 2);
      goal += (p == 3) ? 60 : 256;
      case (p)
        0: foreach (opening[i]) send_byte(opening[i]);
        1: send_frame(16'd1, 16'd1, -1, 10);
        2: begin
          send_frame(16'hFFFF, 16'hFFFF, -1, 10);
          send_frame(16'h0000, 16'h0000, -1, 10);
        end
        3: send_frame(16'd300, 16'd300, -1, 10);
        default: ;
      endcase
      while (bytes_sent < goal) begin
        r = $urandom_range(99);
        pick_ranges(base[p], ra, rb);
        if (r < 62) begin
          send_frame(ra, rb, -1, 10);
        end else if (r < 72) begin
          send_frame(16'($urandom_range(65535)), 16'($urandom_range(65535)), -1, 10);
        end else if (r < 82) begin
          sel = $urandom_range(3);
          send_frame(ra, rb, (sel == 3) ? 5 : sel, 10);
        end else if (r < 90) begin
          send_frame(ra, rb, -1, $urandom_range(9, 1));
        end else begin
          for (int n = $urandom_range(12, 1); n > 0; n--) send_byte(8'($urandom_range(255)));
        end
      end
    end

    settle();
    if (sb.fails == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
